>>> hdl/mwrm_pkg.sv
package mwrm_pkg;

	// Field and register widths
	localparam int SMP_W     = 16;
	localparam int STEP_W    = 15;
	localparam int WGT_W     = 16;
	localparam int CM_W      = 15;
	localparam int GAIN_W    = 48;
	localparam int CFG_IDX_W = 4;

	// Oscillator
	localparam int DEF_PHASE_MODULUS = 48000;
	localparam int STEP_MIN          = 1;
	localparam int STEP_MAX          = 20000;
	localparam int QUO_W             = 17;   // floor(p*2^17/N) bits
	localparam int TRI_BITS          = 15;   // divider step at which p*2^15 mod N is known

	// Sine polynomial coefficients, Q15
	localparam logic [15:0] SIN_A = 16'd51472;
	localparam logic [15:0] SIN_B = 16'd21024;
	localparam logic [15:0] SIN_C = 16'd2320;

	// Shared multiply-accumulate unit: radix-16 digits, multiplier LSB first
	localparam int ACC_W   = 52;
	localparam int DIG_W   = 4;
	localparam int NUM_DIG = 5;
	localparam int B_W     = DIG_W * NUM_DIG;

	// Intermediate widths
	localparam int SN_W  = 18;
	localparam int SUM_W = 34;
	localparam int MOD_W = 24;
	localparam int MIX_W = 26;
	localparam int SH_W  = ACC_W - 14;

	typedef struct packed {
		logic signed [SMP_W-1:0] left_sample;
		logic signed [SMP_W-1:0] right_sample;
	} sample_t;

	typedef struct packed {
		logic signed [SMP_W-1:0] left_out;
		logic signed [SMP_W-1:0] right_out;
	} result_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PHASE_STEP    = 4'd0,
		CFG_STEREO_MODE   = 4'd1,
		CFG_SIN_WEIGHT    = 4'd2,
		CFG_TRI_WEIGHT    = 4'd3,
		CFG_SAW_WEIGHT    = 4'd4,
		CFG_SQUARE_WEIGHT = 4'd5,
		CFG_CROSS_MIX     = 4'd6,
		CFG_OUTPUT_GAINS  = 4'd7
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_LOAD,
		ST_MUL,
		ST_WB
	} state_t;

	// Multiplicand sources
	typedef enum logic [3:0] {
		A_X, A_X2, A_SN, A_TRI, A_SAW, A_SQU, A_SUM,
		A_ML, A_MR, A_SL, A_SR, A_XL, A_XR
	} a_sel_t;

	// Multiplier sources
	typedef enum logic [3:0] {
		B_X, B_C2320, B_T, B_SINW, B_TRIW, B_SAWW, B_SQW,
		B_CL, B_CR, B_OWN, B_CM, B_DRY, B_WL, B_WR
	} b_sel_t;

	// Write-back targets
	typedef enum logic [3:0] {
		D_NONE, D_X2, D_INNER, D_MID, D_SN, D_SUM,
		D_ML, D_MR, D_XL, D_XR, D_OL, D_OR
	} dst_t;

	typedef struct packed {
		a_sel_t a_sel;
		b_sel_t b_sel;
		logic   clr;
		dst_t   dst;
	} op_ctrl_t;

	localparam int NUM_OPS = 18;
	localparam int OP_W    = $clog2(NUM_OPS);

	// Microprogram of the per-sample computation
	function automatic op_ctrl_t op_decode(input logic [OP_W-1:0] op);
		op_ctrl_t c;
		unique case (op)
			5'd0:    c = '{a_sel: A_X,   b_sel: B_X,     clr: 1'b1, dst: D_X2};
			5'd1:    c = '{a_sel: A_X2,  b_sel: B_C2320, clr: 1'b1, dst: D_INNER};
			5'd2:    c = '{a_sel: A_X2,  b_sel: B_T,     clr: 1'b1, dst: D_MID};
			5'd3:    c = '{a_sel: A_X,   b_sel: B_T,     clr: 1'b1, dst: D_SN};
			5'd4:    c = '{a_sel: A_SN,  b_sel: B_SINW,  clr: 1'b1, dst: D_NONE};
			5'd5:    c = '{a_sel: A_TRI, b_sel: B_TRIW,  clr: 1'b0, dst: D_NONE};
			5'd6:    c = '{a_sel: A_SAW, b_sel: B_SAWW,  clr: 1'b0, dst: D_NONE};
			5'd7:    c = '{a_sel: A_SQU, b_sel: B_SQW,   clr: 1'b0, dst: D_SUM};
			5'd8:    c = '{a_sel: A_SUM, b_sel: B_CL,    clr: 1'b1, dst: D_ML};
			5'd9:    c = '{a_sel: A_SUM, b_sel: B_CR,    clr: 1'b1, dst: D_MR};
			5'd10:   c = '{a_sel: A_ML,  b_sel: B_OWN,   clr: 1'b1, dst: D_NONE};
			5'd11:   c = '{a_sel: A_MR,  b_sel: B_CM,    clr: 1'b0, dst: D_XL};
			5'd12:   c = '{a_sel: A_MR,  b_sel: B_OWN,   clr: 1'b1, dst: D_NONE};
			5'd13:   c = '{a_sel: A_ML,  b_sel: B_CM,    clr: 1'b0, dst: D_XR};
			5'd14:   c = '{a_sel: A_SL,  b_sel: B_DRY,   clr: 1'b1, dst: D_NONE};
			5'd15:   c = '{a_sel: A_XL,  b_sel: B_WL,    clr: 1'b0, dst: D_OL};
			5'd16:   c = '{a_sel: A_SR,  b_sel: B_DRY,   clr: 1'b1, dst: D_NONE};
			5'd17:   c = '{a_sel: A_XR,  b_sel: B_WR,    clr: 1'b0, dst: D_OR};
			default: c = '{a_sel: A_X,   b_sel: B_X,     clr: 1'b1, dst: D_NONE};
		endcase
		return c;
	endfunction

	// Clamp to the 16-bit sample range
	function automatic logic signed [SMP_W-1:0] sat16(input logic signed [SH_W-1:0] v);
		logic signed [SH_W-1:0] hi;
		logic signed [SH_W-1:0] lo;
		hi = SH_W'(32767);
		lo = SH_W'(-32768);
		if (v > hi) begin
			return 16'sh7FFF;
		end else if (v < lo) begin
			return 16'sh8000;
		end else begin
			return v[SMP_W-1:0];
		end
	endfunction

endpackage

>>> hdl/multiwave_ring_modulator.sv
// One sample pair at a time: a new pair is accepted only in idle, after the previous pair's
// products are done. Each pair runs a 17-step bit-serial phase divider, then 18 products on
// one shared 52 x 4-bit multiply-accumulate unit.
// The output register lets the next pair be accepted while a result waits.
// Reset (arst_n low, asynchronous): phase 0, registers at their defaults
// (step 440, mono, sine weight 1638, cross 10240, gains 0), no result pending.
module multiwave_ring_modulator #(
	parameter int PHASE_MODULUS = mwrm_pkg::DEF_PHASE_MODULUS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               sample_valid,
	output logic                               sample_ready,
	input  mwrm_pkg::sample_t                  sample,
	output logic                               result_valid,
	input  logic                               result_ready,
	output mwrm_pkg::result_t                  result,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [mwrm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mwrm_pkg::GAIN_W-1:0]        cfg_data
);
	import mwrm_pkg::*;

	localparam int P_W  = $clog2(PHASE_MODULUS);
	localparam int PS_W = $clog2(PHASE_MODULUS + STEP_MAX);
	localparam int DC_W = $clog2(QUO_W);
	localparam int DG_W = $clog2(NUM_DIG);
	localparam logic [P_W:0]      MOD_P1   = (P_W+1)'(PHASE_MODULUS);
	localparam logic [PS_W-1:0]   MOD_PS   = PS_W'(PHASE_MODULUS);
	localparam logic [P_W-1:0]    HALF_P   = P_W'(PHASE_MODULUS / 2);
	localparam logic [DC_W-1:0]   DIV_LAST = DC_W'(QUO_W - 1);
	localparam logic [DC_W-1:0]   TRI_CNT  = DC_W'(TRI_BITS - 1);
	localparam logic [DG_W-1:0]   DIG_LAST = DG_W'(NUM_DIG - 1);
	localparam logic [OP_W-1:0]   OP_LAST  = OP_W'(NUM_OPS - 1);

	// Configuration registers
	logic [STEP_W-1:0]        step_q;
	logic                     stereo_q;
	logic signed [WGT_W-1:0]  sin_w_q;
	logic signed [WGT_W-1:0]  tri_w_q;
	logic signed [WGT_W-1:0]  saw_w_q;
	logic signed [WGT_W-1:0]  sq_w_q;
	logic [CM_W-1:0]          cm_q;
	logic [GAIN_W-1:0]        gains_q;

	// Control
	state_t                   state_q, state_d;
	logic [PS_W-1:0]          phase_q;
	logic [DC_W-1:0]          div_cnt_q;
	logic [DG_W-1:0]          dig_cnt_q;
	logic [OP_W-1:0]          op_q;
	logic                     result_valid_q;

	// Datapath
	logic [P_W-1:0]           p_q;
	logic signed [SMP_W-1:0]  sl_q, sr_q;
	logic [P_W-1:0]           rem_q;
	logic [QUO_W-1:0]         quo_q;
	logic                     nz_q;
	logic signed [ACC_W-1:0]  a_q;
	logic [B_W-1:0]           b_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic [15:0]              x2_q;
	logic [15:0]              t_q;
	logic signed [SN_W-1:0]   sn_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic signed [MOD_W-1:0]  ml_q, mr_q;
	logic signed [MIX_W-1:0]  xl_q, xr_q;
	logic signed [SMP_W-1:0]  ol_q;
	result_t                  result_q;

	logic                     in_fire;
	logic                     out_free;
	logic                     last_op;
	logic                     last_dig;
	logic                     wb_go;
	logic [STEP_W-1:0]        step_eff;
	op_ctrl_t                 ctrl;

	assign cfg_ready    = 1'b1;
	assign result_valid = result_valid_q;
	assign result       = result_q;
	assign in_fire      = sample_valid && sample_ready;
	assign out_free     = !result_valid_q || result_ready;
	assign ctrl         = op_decode(op_q);
	assign last_op      = (op_q == OP_LAST);
	assign last_dig     = (dig_cnt_q == DIG_LAST);
	assign wb_go        = (state_q == ST_WB) && (!last_op || out_free);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q   <= STEP_W'(440);
			stereo_q <= 1'b0;
			sin_w_q  <= 16'sd1638;
			tri_w_q  <= '0;
			saw_w_q  <= '0;
			sq_w_q   <= '0;
			cm_q     <= CM_W'(10240);
			gains_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_PHASE_STEP:    step_q   <= cfg_data[STEP_W-1:0];
				CFG_STEREO_MODE:   stereo_q <= cfg_data[0];
				CFG_SIN_WEIGHT:    sin_w_q  <= cfg_data[WGT_W-1:0];
				CFG_TRI_WEIGHT:    tri_w_q  <= cfg_data[WGT_W-1:0];
				CFG_SAW_WEIGHT:    saw_w_q  <= cfg_data[WGT_W-1:0];
				CFG_SQUARE_WEIGHT: sq_w_q   <= cfg_data[WGT_W-1:0];
				CFG_CROSS_MIX:     cm_q     <= cfg_data[CM_W-1:0];
				CFG_OUTPUT_GAINS:  gains_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Step limited to the legal frequency range
	always_comb begin
		if (step_q < STEP_W'(STEP_MIN)) begin
			step_eff = STEP_W'(STEP_MIN);
		end else if (step_q > STEP_W'(STEP_MAX)) begin
			step_eff = STEP_W'(STEP_MAX);
		end else begin
			step_eff = step_q;
		end
	end

	// Sequencer: next state and handshake
	always_comb begin
		state_d      = state_q;
		sample_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				sample_ready = 1'b1;
				if (sample_valid) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_cnt_q == DIV_LAST) begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: state_d = ST_MUL;
			ST_MUL: begin
				if (last_dig) begin
					state_d = ST_WB;
				end
			end
			ST_WB: begin
				if (wb_go) begin
					state_d = last_op ? ST_IDLE : ST_LOAD;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			phase_q        <= '0;
			div_cnt_q      <= '0;
			dig_cnt_q      <= '0;
			op_q           <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			// Phase advance, reduced mod N one subtract per divider cycle
			if (in_fire) begin
				phase_q <= phase_q + PS_W'(step_eff);
			end else if (state_q == ST_DIV && phase_q >= MOD_PS) begin
				phase_q <= phase_q - MOD_PS;
			end

			if (in_fire) begin
				div_cnt_q <= '0;
			end else if (state_q == ST_DIV) begin
				div_cnt_q <= div_cnt_q + 1'b1;
			end

			if (state_q == ST_LOAD) begin
				dig_cnt_q <= '0;
			end else if (state_q == ST_MUL) begin
				dig_cnt_q <= dig_cnt_q + 1'b1;
			end

			if (state_q == ST_DIV) begin
				op_q <= '0;
			end else if (wb_go && !last_op) begin
				op_q <= op_q + 1'b1;
			end

			if (wb_go && last_op) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// Restoring divider step: p*2^k / N, one quotient bit per cycle
	logic [P_W:0]   rem2;
	logic           q_bit;
	logic [P_W-1:0] rem_nxt;

	assign rem2    = {rem_q, 1'b0};
	assign q_bit   = (rem2 >= MOD_P1);
	assign rem_nxt = q_bit ? P_W'(rem2 - MOD_P1) : rem2[P_W-1:0];

	// Waveform values from the quotient
	logic [1:0]               qd;
	logic [14:0]              r_off;
	logic [15:0]              x_val;
	logic signed [15:0]       saw_val;
	logic [14:0]              q4;
	logic                     low_half;
	logic [14:0]              tq;
	logic signed [15:0]       tri_val;
	logic signed [16:0]       squ_val;

	assign qd       = quo_q[QUO_W-1 -: 2];
	assign r_off    = quo_q[14:0];
	assign x_val    = qd[0] ? (16'h8000 - {1'b0, r_off}) : {1'b0, r_off};
	assign saw_val  = {~quo_q[QUO_W-1], quo_q[QUO_W-2:1]};
	assign q4       = quo_q[QUO_W-1:2];
	assign low_half = ({p_q, 1'b0} < MOD_P1);
	assign tq       = low_half ? q4 : 15'(16'h8000 - {1'b0, q4} - {15'b0, nz_q});
	assign tri_val  = {1'b1, tq};
	assign squ_val  = {!(p_q < HALF_P), 1'b1, 15'b0};

	// Carriers and cross-mix gains
	logic signed [16:0] cl, cr;
	logic signed [15:0] own;

	assign cl  = 17'(sl_q) + 17'(stereo_q ? sl_q : sr_q);
	assign cr  = 17'(sr_q) + 17'(stereo_q ? sr_q : sl_q);
	assign own = $signed(16'd16384 - 16'(cm_q));

	// Operand selection
	logic signed [ACC_W-1:0] a_op;
	logic [B_W-1:0]          b_op;

	always_comb begin
		unique case (ctrl.a_sel)
			A_X:     a_op = ACC_W'(x_val);
			A_X2:    a_op = ACC_W'(x2_q);
			A_SN:    a_op = ACC_W'(sn_q);
			A_TRI:   a_op = ACC_W'(tri_val);
			A_SAW:   a_op = ACC_W'(saw_val);
			A_SQU:   a_op = ACC_W'(squ_val);
			A_SUM:   a_op = ACC_W'(sum_q);
			A_ML:    a_op = ACC_W'(ml_q);
			A_MR:    a_op = ACC_W'(mr_q);
			A_SL:    a_op = ACC_W'(sl_q);
			A_SR:    a_op = ACC_W'(sr_q);
			A_XL:    a_op = ACC_W'(xl_q) <<< 6;
			A_XR:    a_op = ACC_W'(xr_q) <<< 6;
			default: a_op = '0;
		endcase
	end

	always_comb begin
		unique case (ctrl.b_sel)
			B_X:     b_op = B_W'(x_val);
			B_C2320: b_op = B_W'(SIN_C);
			B_T:     b_op = B_W'(t_q);
			B_SINW:  b_op = B_W'(sin_w_q);
			B_TRIW:  b_op = B_W'(tri_w_q);
			B_SAWW:  b_op = B_W'(saw_w_q);
			B_SQW:   b_op = B_W'(sq_w_q);
			B_CL:    b_op = B_W'(cl);
			B_CR:    b_op = B_W'(cr);
			B_OWN:   b_op = B_W'(own);
			B_CM:    b_op = B_W'(cm_q);
			B_DRY:   b_op = B_W'(gains_q[47:32]);
			B_WL:    b_op = B_W'($signed(gains_q[31:16]));
			B_WR:    b_op = B_W'($signed(gains_q[15:0]));
			default: b_op = '0;
		endcase
	end

	// Partial product: top digit of the multiplier carries the sign
	logic signed [DIG_W:0]   digit;
	logic signed [ACC_W-1:0] pp;

	assign digit = last_dig ? {b_q[DIG_W-1], b_q[DIG_W-1:0]} : {1'b0, b_q[DIG_W-1:0]};
	assign pp    = a_q * ACC_W'(digit);

	// Write-back values
	logic [16:0]             s_mag;
	logic signed [SN_W-1:0]  s_ext;
	logic signed [SN_W-1:0]  sn_nxt;
	logic signed [SH_W-1:0]  sh14;

	assign s_mag  = acc_q[31:15];
	assign s_ext  = {1'b0, s_mag};
	assign sn_nxt = qd[1] ? -s_ext : s_ext;
	assign sh14   = acc_q[ACC_W-1:14];

	// Datapath registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			sl_q  <= sample.left_sample;
			sr_q  <= sample.right_sample;
			p_q   <= phase_q[P_W-1:0];
			rem_q <= phase_q[P_W-1:0];
		end

		if (state_q == ST_DIV) begin
			rem_q <= rem_nxt;
			quo_q <= {quo_q[QUO_W-2:0], q_bit};
			if (div_cnt_q == TRI_CNT) begin
				nz_q <= (rem_nxt != '0);
			end
		end

		if (state_q == ST_LOAD) begin
			a_q <= a_op;
			b_q <= b_op;
			if (ctrl.clr) begin
				acc_q <= '0;
			end
		end

		if (state_q == ST_MUL) begin
			acc_q <= acc_q + pp;
			a_q   <= a_q <<< DIG_W;
			b_q   <= b_q >> DIG_W;
		end

		if (wb_go) begin
			unique case (ctrl.dst)
				D_NONE:  ;
				D_X2:    x2_q  <= acc_q[30:15];
				D_INNER: t_q   <= SIN_B - acc_q[30:15];
				D_MID:   t_q   <= SIN_A - acc_q[30:15];
				D_SN:    sn_q  <= sn_nxt;
				D_SUM:   sum_q <= acc_q[SUM_W-1:0];
				D_ML:    ml_q  <= acc_q[27+MOD_W-1:27];
				D_MR:    mr_q  <= acc_q[27+MOD_W-1:27];
				D_XL:    xl_q  <= acc_q[14+MIX_W-1:14];
				D_XR:    xr_q  <= acc_q[14+MIX_W-1:14];
				D_OL:    ol_q  <= sat16(sh14);
				D_OR: begin
					result_q.left_out  <= ol_q;
					result_q.right_out <= sat16(sh14);
				end
				default: ;
			endcase
		end
	end

endmodule
